FILE: rtl/core/tti_pkg.sv
// shared types, constants and register addresses of the taper table interpolator
`timescale 1ns / 1ps
package tti_pkg;
    localparam int MaxEntries = 16;
    localparam int IdxW = $clog2(MaxEntries);
    localparam int CntW = $clog2(MaxEntries + 1);
    localparam logic [15:0] DefaultSpeedReset = 16'd140;
    localparam logic [32:0] MinSpan = 33'd65;
    localparam logic [0:0] OpWrite = 1'b0;
    localparam logic [0:0] OpQuery = 1'b1;
    localparam logic [1:0] StInterp = 2'd0;
    localparam logic [1:0] StOneSide = 2'd1;
    localparam logic [1:0] StNone = 2'd2;
    localparam logic [0:0] RegEntryCount = 1'b0;
    localparam logic [0:0] RegDefaultSpeed = 1'b1;

    typedef struct packed {
        logic signed [15:0] lk;
        logic signed [15:0] rk;
        logic        [15:0] sp;
    } tti_vals_t;

    typedef struct packed {
        logic        start;
        logic [47:0] dividend;
        logic [31:0] divisor;
    } tti_div_req_t;
endpackage

FILE: rtl/core/tti_divider.sv
// restoring divider, one quotient bit per cycle, 48 by 32 bits
`timescale 1ns / 1ps
module tti_divider
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tti_pkg::tti_div_req_t req,
    output logic                  done,
    output logic [31:0]           quotient
);
    logic [47:0] quo_reg;
    logic [47:0] quo_next;
    logic [32:0] rem_reg;
    logic [32:0] rem_next;
    logic [31:0] dvs_reg;
    logic [5:0]  cnt_reg;
    logic [5:0]  cnt_next;
    logic        busy_reg;
    logic        busy_next;
    logic        done_reg;
    logic        done_next;
    logic [32:0] trial;

    always_comb
    begin
        trial     = {rem_reg[31:0], quo_reg[47]};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd47)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (req.start)
        begin
            dvs_reg <= req.divisor;
        end
    end

    assign done = done_reg;
    assign quotient = (quo_reg[47:32] != 16'd0) ? 32'hFFFF_FFFF : quo_reg[31:0];
endmodule

FILE: rtl/core/taper_table_interpolator.sv
// top level of the taper table interpolator: table memory, walk sequencer, blend
`timescale 1ns / 1ps
// channel  | handshake      | payload
// in       | in_valid/stall | operation, entry_index, lengths, kerfs, speed, taper_query
// out      | out_valid/stall| left/right_kerf_result, speed_result, result_status
// cfg      | apb write/read | entry_count (0x0), default_speed (0x4)
// a write item is stored when accepted; a query is accepted, then each entry in use is
// read and both its views divided on the shared bit-serial divider (a view with a zero
// divisor length skips it); the block takes no new item until the query has finished
// a one-side or empty query skips the weight divide and blend
// reset sets control and config registers only; the table is undefined until written
// a finished result waits in the output register while the next items are taken; a
// query holds before its output stage until that result is delivered
module taper_table_interpolator
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               operation,
    input  logic [3:0]         entry_index,
    input  logic [15:0]        left_side_len,
    input  logic [15:0]        right_side_len,
    input  logic signed [15:0] left_kerf_value,
    input  logic signed [15:0] right_kerf_value,
    input  logic [15:0]        speed_value,
    input  logic [31:0]        taper_query,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] left_kerf_result,
    output logic signed [15:0] right_kerf_result,
    output logic [15:0]        speed_result,
    output logic [1:0]         result_status,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_WDIV  = 3'd3;
    localparam logic [2:0] S_BLEND = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [79:0] mem [tti_pkg::MaxEntries];
    logic [79:0] rd_reg;

    logic [4:0]  count_reg;
    logic [15:0] dspeed_reg;
    logic [2:0]  st_reg;
    logic [tti_pkg::IdxW-1:0] idx_reg;
    logic        pass_reg;
    logic        divwait_reg;
    logic [31:0] q_reg;
    logic        lo_ok_reg;
    logic        hi_ok_reg;
    logic [31:0] lo_r_reg;
    logic [31:0] hi_r_reg;
    tti_pkg::tti_vals_t lo_v_reg;
    tti_pkg::tti_vals_t hi_v_reg;
    tti_pkg::tti_vals_t cur_v;
    logic [15:0] k_reg;
    logic [1:0]  bl_reg;
    logic signed [17:0] acc_a_reg;
    logic signed [17:0] acc_b_reg;
    logic signed [35:0] prod_reg;
    tti_pkg::tti_vals_t res_reg;
    logic [1:0]  stat_reg;
    logic        ov_reg;

    tti_pkg::tti_div_req_t dreq;
    logic        ddone;
    logic [31:0] dquo;
    logic [tti_pkg::CntW-1:0] n_eff;
    logic        last_view;
    logic        in_acc;
    logic        cfg_wr;
    logic [15:0] a_len;
    logic [15:0] b_len;
    logic [32:0] span;
    logic signed [35:0] blend_sum;

    tti_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quotient(dquo));

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == tti_pkg::RegDefaultSpeed) ? {16'd0, dspeed_reg}
                                                            : {27'd0, count_reg};
    assign n_eff = (count_reg > 5'(tti_pkg::MaxEntries)) ? tti_pkg::CntW'(tti_pkg::MaxEntries)
                                                         : tti_pkg::CntW'(count_reg);
    assign in_stall = (st_reg != S_IDLE);
    assign in_acc = in_valid && !in_stall;
    assign out_valid = ov_reg;
    assign left_kerf_result = res_reg.lk;
    assign right_kerf_result = res_reg.rk;
    assign speed_result = res_reg.sp;
    assign result_status = stat_reg;

    assign a_len = pass_reg ? rd_reg[79:64] : rd_reg[63:48];
    assign b_len = pass_reg ? rd_reg[63:48] : rd_reg[79:64];
    assign cur_v.lk = pass_reg ? rd_reg[47:32] : rd_reg[31:16];
    assign cur_v.rk = pass_reg ? rd_reg[31:16] : rd_reg[47:32];
    assign cur_v.sp = rd_reg[15:0];
    assign last_view = pass_reg && ({1'b0, idx_reg} == (n_eff - 1'b1));
    assign span = {1'b0, hi_r_reg} - {1'b0, lo_r_reg};
    assign blend_sum = prod_reg + 36'sd32768;

    always_comb
    begin
        dreq.start = 1'b0;
        dreq.dividend = {a_len, 32'd0} >> 16;
        dreq.divisor = {16'd0, b_len};
        if (st_reg == S_DIV && !divwait_reg && b_len != 16'd0)
        begin
            dreq.start = 1'b1;
        end
        else if (st_reg == S_WDIV && !divwait_reg && !ov_reg && lo_ok_reg && hi_ok_reg
                 && span > tti_pkg::MinSpan)
        begin
            dreq.start = 1'b1;
            dreq.dividend = {q_reg - lo_r_reg, 16'd0};
            dreq.divisor = span[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && operation == tti_pkg::OpWrite)
        begin
            mem[entry_index] <= {right_side_len, left_side_len, right_kerf_value,
                                 left_kerf_value, speed_value};
        end
        rd_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dspeed_reg  <= tti_pkg::DefaultSpeedReset;
            st_reg      <= S_IDLE;
            ov_reg      <= 1'b0;
            divwait_reg <= 1'b0;
            idx_reg     <= '0;
            pass_reg    <= 1'b0;
            lo_ok_reg   <= 1'b0;
            hi_ok_reg   <= 1'b0;
            bl_reg      <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                if (paddr[2] == tti_pkg::RegEntryCount)
                    count_reg <= pwdata[4:0];
                else
                    dspeed_reg <= pwdata[15:0];
            end
            if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE:
                begin
                    if (in_acc && operation == tti_pkg::OpQuery)
                    begin
                        q_reg     <= taper_query;
                        idx_reg   <= '0;
                        pass_reg  <= 1'b0;
                        lo_ok_reg <= 1'b0;
                        hi_ok_reg <= 1'b0;
                        st_reg    <= (n_eff == '0) ? S_WDIV : S_READ;
                    end
                end
                S_READ:
                    st_reg <= S_DIV;
                S_DIV:
                begin
                    if (!divwait_reg && b_len != 16'd0)
                        divwait_reg <= 1'b1;
                    else if (!divwait_reg || ddone)
                    begin
                        divwait_reg <= 1'b0;
                        if (divwait_reg)
                        begin
                            if (dquo <= q_reg && (!lo_ok_reg || dquo > lo_r_reg))
                            begin
                                lo_ok_reg <= 1'b1;
                                lo_r_reg  <= dquo;
                                lo_v_reg  <= cur_v;
                            end
                            if (dquo >= q_reg && (!hi_ok_reg || dquo < hi_r_reg))
                            begin
                                hi_ok_reg <= 1'b1;
                                hi_r_reg  <= dquo;
                                hi_v_reg  <= cur_v;
                            end
                        end
                        if (last_view)
                            st_reg <= S_WDIV;
                        else if (pass_reg)
                        begin
                            pass_reg <= 1'b0;
                            idx_reg  <= idx_reg + 1'b1;
                            st_reg   <= S_READ;
                        end
                        else
                            pass_reg <= 1'b1;
                    end
                end
                S_WDIV:
                begin
                    // hold until the previous result has left the output register
                    if (!ov_reg)
                    begin
                        if (!(lo_ok_reg && hi_ok_reg))
                        begin
                            stat_reg <= (lo_ok_reg || hi_ok_reg) ? tti_pkg::StOneSide
                                                                 : tti_pkg::StNone;
                            st_reg <= S_OUT;
                        end
                        else if (span <= tti_pkg::MinSpan)
                        begin
                            k_reg  <= '0;
                            bl_reg <= '0;
                            st_reg <= S_BLEND;
                        end
                        else if (!divwait_reg)
                            divwait_reg <= 1'b1;
                        else if (ddone)
                        begin
                            divwait_reg <= 1'b0;
                            k_reg  <= (dquo > 32'd65535) ? 16'hFFFF : dquo[15:0];
                            bl_reg <= '0;
                            st_reg <= S_BLEND;
                        end
                    end
                end
                S_BLEND:
                begin
                    case (bl_reg)
                        2'd0:
                        begin
                            acc_a_reg <= 18'(lo_v_reg.lk);
                            acc_b_reg <= 18'(hi_v_reg.lk);
                        end
                        2'd1:
                        begin
                            acc_a_reg <= 18'(lo_v_reg.rk);
                            acc_b_reg <= 18'(hi_v_reg.rk);
                        end
                        default:
                        begin
                            acc_a_reg <= $signed({2'b00, lo_v_reg.sp});
                            acc_b_reg <= $signed({2'b00, hi_v_reg.sp});
                        end
                    endcase
                    if (bl_reg != 2'd0)
                    begin
                        prod_reg <= 36'(acc_a_reg) * 36'sd65536
                                  + 36'(acc_b_reg - acc_a_reg) * $signed({20'd0, k_reg});
                    end
                    bl_reg <= bl_reg + 2'd1;
                    if (bl_reg == 2'd3)
                        st_reg <= S_OUT;
                    stat_reg <= tti_pkg::StInterp;
                end
                S_OUT:
                begin
                    ov_reg <= 1'b1;
                    st_reg <= S_IDLE;
                end
                default:
                    st_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == S_WDIV && !ov_reg && !(lo_ok_reg && hi_ok_reg))
        begin
            if (lo_ok_reg)
                res_reg <= lo_v_reg;
            else if (hi_ok_reg)
                res_reg <= hi_v_reg;
            else
                res_reg <= '{lk: 16'sd0, rk: 16'sd0, sp: dspeed_reg};
        end
        else if (st_reg == S_BLEND)
        begin
            if (bl_reg == 2'd2)
                res_reg.lk <= blend_sum[31:16];
            else if (bl_reg == 2'd3)
                res_reg.rk <= blend_sum[31:16];
        end
        else if (st_reg == S_OUT && stat_reg == tti_pkg::StInterp)
            res_reg.sp <= blend_sum[31:16];
    end
endmodule
